### hdl/stt_pkg.sv
// Shared types, widths and token kind codes of the source text tokenizer
package stt_pkg;

   localparam int FIELD_W     = 16;
   localparam int KIND_W      = 4;
   localparam int BYTE_W      = 8;
   localparam int DATA_W      = 2 * FIELD_W;
   localparam int USER_W      = KIND_W + 3;
   localparam int SLOTS       = 4;
   localparam int SLOT_IDX_W  = $clog2(SLOTS);
   localparam int QUEUE_DEPTH = 4;

   // result slots of one byte, in delivery order
   localparam int SLOT_CLOSE  = 0;
   localparam int SLOT_PUNCT  = 1;
   localparam int SLOT_FINISH = 2;
   localparam int SLOT_EOT    = 3;

   localparam logic [KIND_W-1:0] KIND_NONE    = 4'd0;
   localparam logic [KIND_W-1:0] KIND_SEMI    = 4'd0;
   localparam logic [KIND_W-1:0] KIND_ARROW   = 4'd1;
   localparam logic [KIND_W-1:0] KIND_LPAREN  = 4'd2;
   localparam logic [KIND_W-1:0] KIND_RPAREN  = 4'd3;
   localparam logic [KIND_W-1:0] KIND_LBRACE  = 4'd4;
   localparam logic [KIND_W-1:0] KIND_RBRACE  = 4'd5;
   localparam logic [KIND_W-1:0] KIND_PLUS    = 4'd6;
   localparam logic [KIND_W-1:0] KIND_MINUS   = 4'd7;
   localparam logic [KIND_W-1:0] KIND_STAR    = 4'd8;
   localparam logic [KIND_W-1:0] KIND_SLASH   = 4'd9;
   localparam logic [KIND_W-1:0] KIND_INT     = 4'd10;
   localparam logic [KIND_W-1:0] KIND_STRING  = 4'd11;
   localparam logic [KIND_W-1:0] KIND_NUMBER  = 4'd12;
   localparam logic [KIND_W-1:0] KIND_KEYWORD = 4'd13;
   localparam logic [KIND_W-1:0] KIND_IDENT   = 4'd14;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic               tok_valid;
      logic [FIELD_W-1:0] start;
      logic [FIELD_W-1:0] length;
      logic               err;
      logic               eot;
   } result_type;

   typedef struct packed {
      logic [SLOTS-1:0]              en;
      result_type [SLOTS-1:0]        slot;
   } bundle_type;

   function automatic result_type mk_result(input logic [KIND_W-1:0] kind,
                                            input logic tok_valid,
                                            input logic [FIELD_W-1:0] start,
                                            input logic [FIELD_W-1:0] length,
                                            input logic err,
                                            input logic eot);
      result_type r;
      r.kind      = kind;
      r.tok_valid = tok_valid;
      r.start     = start;
      r.length    = length;
      r.err       = err;
      r.eot       = eot;
      return r;
   endfunction

   function automatic result_type mk_token(input logic [KIND_W-1:0] kind,
                                           input logic [FIELD_W-1:0] start,
                                           input logic [FIELD_W-1:0] length);
      return mk_result(kind, 1'b1, start, length, 1'b0, 1'b0);
   endfunction

endpackage

### hdl/stt_front.sv
// Scanner front end: takes text bytes, tracks the scan state, builds result bundles
module stt_front
   import stt_pkg::*;
#(
   parameter int OFFSET_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [BYTE_W-1:0] in_byte,
   input  logic              in_final,
   output logic              push,
   output bundle_type        push_bundle,
   input  logic              queue_ready
);

   localparam logic [2:0] MODE_BETWEEN = 3'd0;
   localparam logic [2:0] MODE_ARROW   = 3'd1;
   localparam logic [2:0] MODE_INTW    = 3'd2;
   localparam logic [2:0] MODE_STRING  = 3'd3;
   localparam logic [2:0] MODE_NUMBER  = 3'd4;
   localparam logic [2:0] MODE_IDENT   = 3'd5;

   localparam logic [BYTE_W-1:0] CH_SEMI   = ";";
   localparam logic [BYTE_W-1:0] CH_LPAREN = "(";
   localparam logic [BYTE_W-1:0] CH_RPAREN = ")";
   localparam logic [BYTE_W-1:0] CH_LBRACE = "{";
   localparam logic [BYTE_W-1:0] CH_RBRACE = "}";
   localparam logic [BYTE_W-1:0] CH_PLUS   = "+";
   localparam logic [BYTE_W-1:0] CH_DASH   = "-";
   localparam logic [BYTE_W-1:0] CH_STAR   = "*";
   localparam logic [BYTE_W-1:0] CH_SLASH  = "/";
   localparam logic [BYTE_W-1:0] CH_LT     = "<";
   localparam logic [BYTE_W-1:0] CH_SPACE  = " ";
   localparam logic [BYTE_W-1:0] CH_I      = "i";
   localparam logic [BYTE_W-1:0] CH_N      = "n";
   localparam logic [BYTE_W-1:0] CH_T      = "t";
   localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
   localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [31:0]       KW_MAIN   = "main";
   localparam logic [31:0]       KW_BACK   = "back";

   function automatic logic is_digit(input logic [BYTE_W-1:0] b);
      return b inside {["0":"9"]};
   endfunction

   function automatic logic is_letter(input logic [BYTE_W-1:0] b);
      return b inside {["a":"z"], ["A":"Z"]};
   endfunction

   // bit 0: "main" still possible, bit 1: "back" still possible
   function automatic logic [1:0] kw_next(input logic [1:0] kw,
                                          input logic [BYTE_W-1:0] b,
                                          input logic [1:0] idx);
      logic [1:0] r;
      r = kw;
      if (b != KW_MAIN[{~idx, 3'b000} +: 8]) r[0] = 1'b0;
      if (b != KW_BACK[{~idx, 3'b000} +: 8]) r[1] = 1'b0;
      return r;
   endfunction

   logic [2:0]             mode_ff, mode_in, mode_f;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in, start_f;
   logic [1:0]             cnt_ff, cnt_in, cnt_f;
   logic [1:0]             kw_ff, kw_in, kw_f;
   logic                   bs_ff, bs_in, bs_f;
   logic                   halted_ff, halted_in;

   logic [OFFSET_BITS-1:0] span, span1, pos_nx, start_nx1, fin_len;
   logic                   accept, overflow, held_hit, run_start, new_start;
   logic                   punct_hit;
   logic [KIND_W-1:0]      punct_kind;
   bundle_type             bnd;

   assign accept    = in_valid && queue_ready;
   assign in_ready  = queue_ready;
   assign span      = pos_ff - start_ff;
   assign span1     = span + OFFSET_BITS'(1);
   assign pos_nx    = pos_ff + OFFSET_BITS'(1);
   assign start_nx1 = start_ff + OFFSET_BITS'(1);
   assign overflow  = (pos_ff == '1);

   assign held_hit = ((cnt_ff == 2'd1) &&
                      (in_byte == ((mode_ff == MODE_ARROW) ? CH_DASH : CH_N))) ||
                     ((cnt_ff == 2'd2) &&
                      (in_byte == ((mode_ff == MODE_ARROW) ? CH_SPACE : CH_T)));

   always_comb begin
      punct_hit  = 1'b1;
      punct_kind = KIND_NONE;
      case (in_byte)
         CH_SEMI:   punct_kind = KIND_SEMI;
         CH_LPAREN: punct_kind = KIND_LPAREN;
         CH_RPAREN: punct_kind = KIND_RPAREN;
         CH_LBRACE: punct_kind = KIND_LBRACE;
         CH_RBRACE: punct_kind = KIND_RBRACE;
         CH_PLUS:   punct_kind = KIND_PLUS;
         CH_DASH:   punct_kind = KIND_MINUS;
         CH_STAR:   punct_kind = KIND_STAR;
         CH_SLASH:  punct_kind = KIND_SLASH;
         default:   punct_hit  = 1'b0;
      endcase
   end

   always_comb begin
      bnd       = '0;
      mode_f    = mode_ff;
      start_f   = start_ff;
      cnt_f     = cnt_ff;
      kw_f      = kw_ff;
      bs_f      = bs_ff;
      run_start = 1'b0;
      new_start = 1'b0;
      fin_len   = '0;
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      start_in  = start_ff;
      cnt_in    = cnt_ff;
      kw_in     = kw_ff;
      bs_in     = bs_ff;
      halted_in = halted_ff;

      if (accept && !halted_ff) begin
         if (overflow) begin
            bnd.en[SLOT_FINISH]   = 1'b1;
            bnd.slot[SLOT_FINISH] = mk_result(KIND_NONE, 1'b0, FIELD_W'(pos_ff), '0,
                                              1'b1, 1'b0);
            halted_in = 1'b1;
         end else begin
            case (mode_ff)
               MODE_ARROW, MODE_INTW: begin
                  if (held_hit) begin
                     if (cnt_ff == 2'd2) begin
                        bnd.en[SLOT_CLOSE]   = 1'b1;
                        bnd.slot[SLOT_CLOSE] = mk_token(
                           (mode_ff == MODE_ARROW) ? KIND_ARROW : KIND_INT,
                           FIELD_W'(start_ff), FIELD_W'(3));
                        mode_f = MODE_BETWEEN;
                        cnt_f  = 2'd0;
                     end else begin
                        cnt_f = 2'd2;
                     end
                  end else if (mode_ff == MODE_ARROW) begin
                     // held '<' is dropped, a held '-' stands alone
                     cnt_f     = 2'd0;
                     mode_f    = MODE_BETWEEN;
                     run_start = 1'b1;
                     if (cnt_ff == 2'd2) begin
                        bnd.en[SLOT_CLOSE]   = 1'b1;
                        bnd.slot[SLOT_CLOSE] = mk_token(KIND_MINUS, FIELD_W'(start_nx1),
                                                        FIELD_W'(1));
                     end
                  end else begin
                     // held "i" or "in" carries on as an identifier, never a keyword
                     cnt_f  = 2'd0;
                     kw_f   = 2'b00;
                     mode_f = MODE_IDENT;
                     if (!is_letter(in_byte)) begin
                        bnd.en[SLOT_CLOSE]   = 1'b1;
                        bnd.slot[SLOT_CLOSE] = mk_token(KIND_IDENT, FIELD_W'(start_ff),
                                                        FIELD_W'(span));
                        mode_f    = MODE_BETWEEN;
                        run_start = 1'b1;
                     end
                  end
               end
               MODE_STRING: begin
                  if ((in_byte == CH_QUOTE) && !bs_ff) begin
                     bnd.en[SLOT_CLOSE]   = 1'b1;
                     bnd.slot[SLOT_CLOSE] = mk_token(KIND_STRING, FIELD_W'(start_ff),
                                                     FIELD_W'(span1));
                     mode_f = MODE_BETWEEN;
                  end else begin
                     bs_f = (in_byte == CH_BSLASH);
                  end
               end
               MODE_NUMBER: begin
                  if (!is_digit(in_byte)) begin
                     bnd.en[SLOT_CLOSE]   = 1'b1;
                     bnd.slot[SLOT_CLOSE] = mk_token(KIND_NUMBER, FIELD_W'(start_ff),
                                                     FIELD_W'(span));
                     mode_f    = MODE_BETWEEN;
                     run_start = 1'b1;
                  end
               end
               MODE_IDENT: begin
                  if (is_letter(in_byte)) begin
                     kw_f = (span < OFFSET_BITS'(4)) ? kw_next(kw_ff, in_byte, span[1:0])
                                                     : 2'b00;
                  end else begin
                     bnd.en[SLOT_CLOSE]   = 1'b1;
                     bnd.slot[SLOT_CLOSE] = mk_token(
                        ((kw_ff != 2'b00) && (span == OFFSET_BITS'(4))) ? KIND_KEYWORD
                                                                        : KIND_IDENT,
                        FIELD_W'(start_ff), FIELD_W'(span));
                     mode_f    = MODE_BETWEEN;
                     run_start = 1'b1;
                  end
               end
               default: begin
                  mode_f    = MODE_BETWEEN;
                  run_start = 1'b1;
               end
            endcase

            if (run_start) begin
               if (punct_hit) begin
                  bnd.en[SLOT_PUNCT]   = 1'b1;
                  bnd.slot[SLOT_PUNCT] = mk_token(punct_kind, FIELD_W'(pos_ff), FIELD_W'(1));
               end else if (in_byte == CH_LT) begin
                  mode_f    = MODE_ARROW;
                  cnt_f     = 2'd1;
                  start_f   = pos_ff;
                  new_start = 1'b1;
               end else if (in_byte == CH_I) begin
                  mode_f    = MODE_INTW;
                  cnt_f     = 2'd1;
                  start_f   = pos_ff;
                  new_start = 1'b1;
               end else if (in_byte == CH_QUOTE) begin
                  mode_f    = MODE_STRING;
                  start_f   = pos_ff;
                  bs_f      = 1'b0;
                  new_start = 1'b1;
               end else if (is_digit(in_byte)) begin
                  mode_f    = MODE_NUMBER;
                  start_f   = pos_ff;
                  new_start = 1'b1;
               end else if (is_letter(in_byte)) begin
                  mode_f    = MODE_IDENT;
                  start_f   = pos_ff;
                  kw_f      = kw_next(2'b11, in_byte, 2'd0);
                  new_start = 1'b1;
               end
            end

            fin_len  = new_start ? OFFSET_BITS'(1) : span1;
            mode_in  = mode_f;
            pos_in   = pos_nx;
            start_in = start_f;
            cnt_in   = cnt_f;
            kw_in    = kw_f;
            bs_in    = bs_f;

            if (in_final) begin
               case (mode_f)
                  MODE_ARROW: begin
                     if (cnt_f == 2'd2) begin
                        bnd.en[SLOT_FINISH]   = 1'b1;
                        bnd.slot[SLOT_FINISH] = mk_token(KIND_MINUS, FIELD_W'(start_nx1),
                                                         FIELD_W'(1));
                     end
                  end
                  MODE_INTW: begin
                     bnd.en[SLOT_FINISH]   = 1'b1;
                     bnd.slot[SLOT_FINISH] = mk_token(KIND_IDENT, FIELD_W'(start_f),
                                                      FIELD_W'(fin_len));
                  end
                  MODE_STRING: begin
                     // unterminated string
                     bnd.en[SLOT_FINISH]   = 1'b1;
                     bnd.slot[SLOT_FINISH] = mk_result(KIND_NONE, 1'b0, FIELD_W'(start_f),
                                                       '0, 1'b1, 1'b0);
                     halted_in = 1'b1;
                  end
                  MODE_NUMBER: begin
                     bnd.en[SLOT_FINISH]   = 1'b1;
                     bnd.slot[SLOT_FINISH] = mk_token(KIND_NUMBER, FIELD_W'(start_f),
                                                      FIELD_W'(fin_len));
                  end
                  MODE_IDENT: begin
                     bnd.en[SLOT_FINISH]   = 1'b1;
                     bnd.slot[SLOT_FINISH] = mk_token(
                        ((kw_f != 2'b00) && (fin_len == OFFSET_BITS'(4))) ? KIND_KEYWORD
                                                                          : KIND_IDENT,
                        FIELD_W'(start_f), FIELD_W'(fin_len));
                  end
                  default: ;
               endcase

               if (mode_f != MODE_STRING) begin
                  bnd.en[SLOT_EOT]   = 1'b1;
                  bnd.slot[SLOT_EOT] = mk_result(KIND_NONE, 1'b0, FIELD_W'(pos_nx), '0,
                                                 1'b0, 1'b1);
                  mode_in  = MODE_BETWEEN;
                  pos_in   = '0;
                  start_in = '0;
                  cnt_in   = 2'd0;
                  kw_in    = 2'b11;
                  bs_in    = 1'b0;
               end
            end
         end
      end
   end

   assign push        = accept && !halted_ff && (bnd.en != '0);
   assign push_bundle = bnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_BETWEEN;
         pos_ff    <= '0;
         start_ff  <= '0;
         cnt_ff    <= 2'd0;
         kw_ff     <= 2'b11;
         bs_ff     <= 1'b0;
         halted_ff <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         start_ff  <= start_in;
         cnt_ff    <= cnt_in;
         kw_ff     <= kw_in;
         bs_ff     <= bs_in;
         halted_ff <= halted_in;
      end
   end

endmodule

### hdl/stt_queue.sv
// Short bundle queue between the scanner and the result serializer
module stt_queue
   import stt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_bundle,
   output logic       push_ready,
   input  logic       pop,
   output bundle_type head,
   output logic       head_valid
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   bundle_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

### hdl/stt_back.sv
// Result serializer: sends the enabled slots of each bundle, one transfer per cycle while out_ready is high
module stt_back
   import stt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  bundle_type head,
   input  logic       head_valid,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result,
   output logic       out_last
);

   logic [SLOTS-1:0]      done_ff, done_in, remain, pick;
   logic [SLOT_IDX_W-1:0] sel;
   logic                  load, final_slot;
   logic                  valid_ff, valid_in;
   result_type            res_ff;
   logic                  last_ff;

   always_comb begin
      remain = head.en & ~done_ff;
      sel    = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (remain[i]) sel = SLOT_IDX_W'(i);
      end
      pick       = SLOTS'(1) << sel;
      final_slot = ((remain & ~pick) == '0);
      // output register is free when empty or being taken this cycle
      load       = head_valid && (!valid_ff || out_ready);
      pop        = load && final_slot;

      done_in  = done_ff;
      valid_in = valid_ff;
      if (load) begin
         done_in  = final_slot ? '0 : (done_ff | pick);
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff  <= head.slot[sel];
         last_ff <= final_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = res_ff;
   assign out_last   = last_ff;

endmodule

### hdl/source_text_tokenizer_unit.sv
// Source text tokenizer: top level joining scanner, queue and serializer
//
// Text enters on the req_ channel, one byte per transfer; req_tlast marks the
// final byte of a text. Tokens leave on the rsp_ channel, one result per
// transfer; rsp_tlast marks the last result caused by a given input byte.
// A byte may cause no result, or up to three (a closing token, a punctuation
// token, a token flushed at the end of text, the end-of-text marker).
// The first result of a byte passes through the bundle queue and then the output
// register before it is shown. Throughput: one byte per cycle while bytes give at
// most one result each and rsp_tready is high; a byte with several results holds
// the output while they are sent, and the four-entry bundle queue absorbs that.
// When rsp_tready is low the output register holds its result, the queue
// fills and req_tready falls once it is full.
// After an error result (unterminated string, offset overflow) bytes are
// still taken but give no results until reset.
// Reset (synchronous) returns the scan state to the start of a text at
// offset 0, empties the queue and drops any result on the output.
module source_text_tokenizer_unit
   import stt_pkg::*;
#(
   parameter int OFFSET_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,   // [7:0] text_byte
   input  logic              req_tlast,   // final_byte
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // [15:0] token_start, [31:16] token_length
   output logic [USER_W-1:0] rsp_tuser,   // [3:0] token_kind, [4] token_valid,
                                          // [5] error_flag, [6] end_of_text
   output logic              rsp_tlast    // last_of_run
);

   logic       push, push_ready, pop, head_valid;
   bundle_type push_bundle, head;
   result_type out_result;

   stt_front #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_final   (req_tlast),
      .push       (push),
      .push_bundle(push_bundle),
      .queue_ready(push_ready)
   );

   stt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_bundle(push_bundle),
      .push_ready (push_ready),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid)
   );

   stt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .head_valid(head_valid),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_result(out_result),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {out_result.length, out_result.start};
   assign rsp_tuser = {out_result.eot, out_result.err, out_result.tok_valid, out_result.kind};

endmodule

### hdl/stt_checker.sv
// Port-level checks of the tokenizer result channel, bound to the top level
module stt_checker
   import stt_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic [USER_W-1:0] rsp_tuser,
   input logic              rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
                                    && $stable(rsp_tlast))
      else $error("stalled result changed");

   // an error result is always the last of its byte
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[KIND_W+1] |-> rsp_tlast)
      else $error("error result not last of run");

   // the end-of-text marker closes its byte and carries no token or error
   a_eot_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[KIND_W+2] |-> rsp_tlast && !rsp_tuser[KIND_W]
                                            && !rsp_tuser[KIND_W+1])
      else $error("malformed end-of-text result");

   // non-token results carry kind and length zero
   a_no_token: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[KIND_W] |-> (rsp_tuser[KIND_W-1:0] == '0)
                                           && (rsp_tdata[DATA_W-1:FIELD_W] == '0))
      else $error("non-token result with kind or length");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown after reset");

endmodule

bind source_text_tokenizer_unit stt_checker u_checker (.*);
